### src/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types, widths and codes for the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_W    = 16;
  localparam int SECTOR_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int DIV_CNT_W  = $clog2(COORD_W + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W:0]   diff_t;
  typedef logic        [COORD_W-1:0] mag_t;
  typedef logic        [SECTOR_W-1:0] sector_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam sector_t SECTOR_COUNT_RST = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTOR_COUNT = 1'b0,
    REG_BBOX_ENABLE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    coord_t  point_x;
    coord_t  point_y;
    sector_t query_sector;
    sector_t edge_sector;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
    logic    last_edge;
  } in_t;

  typedef struct packed {
    logic inside_res;
    logic box_rejected;
  } out_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic mul;
    logic div_start;
    logic cmp;
    logic res_load;
  } pip_cmd_t;

  typedef struct packed {
    logic match;
    logic straddle;
    logic last;
    logic div_done;
  } pip_status_t;

endpackage

### src/pip_div.sv
// ----------------------------------------------------------------------------
// pip_div
// Radix-2 restoring divider, one quotient bit per cycle. The quotient is
// known to fit COORD_W bits, so the upper half of the dividend seeds the
// partial remainder.
// ----------------------------------------------------------------------------
module pip_div
  import pip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2*COORD_W-1:0]   dividend,
  input  mag_t                   divisor,
  output logic                   done,
  output mag_t                   quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  mag_t                 rem;
  mag_t                 dvd;
  mag_t                 dsr;
  logic [COORD_W:0]     shifted;
  logic [COORD_W+1:0]   trial;

  assign shifted = {rem, dvd[COORD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(COORD_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[2*COORD_W-1:COORD_W];
      dvd      <= dividend[COORD_W-1:0];
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      dvd <= {dvd[COORD_W-2:0], 1'b0};
      if (!trial[COORD_W+1]) begin
        rem      <= trial[COORD_W-1:0];
        quotient <= {quotient[COORD_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[COORD_W-1:0];
        quotient <= {quotient[COORD_W-2:0], 1'b0};
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not go busy after start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
      done |-> ($past(busy) && !busy))
    else $error("divider done without a running division");
`endif

endmodule

### src/pip_dp.sv
// ----------------------------------------------------------------------------
// pip_dp
// Datapath: edge capture, crossing arithmetic, bounding box, parity and
// result register.
// ----------------------------------------------------------------------------
module pip_dp
  import pip_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pip_cmd_t    cmd,
  output pip_status_t status,
  input  in_t         in_data,
  input  sector_t     sector_count,
  input  logic        bbox_enable,
  output out_t        out_data
);

  function automatic diff_t coord_diff(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = {a[COORD_W-1], a};
    eb = {b[COORD_W-1], b};
    return ea - eb;
  endfunction

  function automatic mag_t abs_diff(diff_t v);
    diff_t n;
    n = -v;
    return v[COORD_W] ? n[COORD_W-1:0] : v[COORD_W-1:0];
  endfunction

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  in_t                   item;
  mag_t                  mag_dx;
  mag_t                  mag_n;
  mag_t                  mag_d;
  logic                  neg;
  logic [2*COORD_W-1:0]  product;
  mag_t                  quo;
  logic                  div_done;

  logic                  parity;
  logic                  any_edge_seen;
  coord_t                box_top;
  coord_t                box_bottom;
  coord_t                box_left;
  coord_t                box_right;

  diff_t                 dx;
  diff_t                 dn;
  diff_t                 dd;
  diff_t                 q_mag;
  diff_t                 q_signed;
  logic signed [COORD_W+1:0] cross_x;
  logic signed [COORD_W+1:0] px_ext;
  logic                  crossed;

  coord_t                eff_top;
  coord_t                eff_bottom;
  coord_t                eff_left;
  coord_t                eff_right;
  logic                  outside;
  logic                  in_range;
  out_t                  result;

  assign dx = coord_diff(item.end_x, item.start_x);
  assign dn = coord_diff(item.point_y, item.start_y);
  assign dd = coord_diff(item.end_y, item.start_y);

  assign status.match    = (item.edge_sector == item.query_sector);
  assign status.straddle = (item.start_y > item.point_y) != (item.end_y > item.point_y);
  assign status.last     = item.last_edge;
  assign status.div_done = div_done;

  pip_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (mag_d),
    .done     (div_done),
    .quotient (quo)
  );

  // truncation toward zero: sign applied to the unsigned quotient
  assign q_mag    = {1'b0, quo};
  assign q_signed = neg ? -q_mag : q_mag;
  assign cross_x  = {q_signed[COORD_W], q_signed}
                  + {{2{item.start_x[COORD_W-1]}}, item.start_x};
  assign px_ext   = {{2{item.point_x[COORD_W-1]}}, item.point_x};
  assign crossed  = px_ext < cross_x;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.eval) begin
      mag_dx <= abs_diff(dx);
      mag_n  <= abs_diff(dn);
      mag_d  <= abs_diff(dd);
      neg    <= dx[COORD_W] ^ dn[COORD_W] ^ dd[COORD_W];
    end
    if (cmd.mul) begin
      product <= {{COORD_W{1'b0}}, mag_dx} * {{COORD_W{1'b0}}, mag_n};
    end
    if (cmd.res_load) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.res_load) begin
      parity        <= 1'b0;
      any_edge_seen <= 1'b0;
      box_top       <= COORD_MIN;
      box_bottom    <= COORD_MAX;
      box_left      <= COORD_MAX;
      box_right     <= COORD_MIN;
    end else begin
      if (cmd.eval && status.match) begin
        any_edge_seen <= 1'b1;
        box_top       <= cmax(box_top, cmax(item.start_y, item.end_y));
        box_bottom    <= cmin(box_bottom, cmin(item.start_y, item.end_y));
        box_left      <= cmin(box_left, cmin(item.start_x, item.end_x));
        box_right     <= cmax(box_right, cmax(item.start_x, item.end_x));
      end
      if (cmd.cmp && crossed) begin
        parity <= ~parity;
      end
    end
  end

  // an empty box counts as the single point at the origin
  assign eff_top    = any_edge_seen ? box_top    : '0;
  assign eff_bottom = any_edge_seen ? box_bottom : '0;
  assign eff_left   = any_edge_seen ? box_left   : '0;
  assign eff_right  = any_edge_seen ? box_right  : '0;

  assign outside = (item.point_x < eff_left) || (item.point_x > eff_right)
                || (item.point_y < eff_bottom) || (item.point_y > eff_top);
  assign in_range = item.query_sector < sector_count;

  assign result.box_rejected = in_range && bbox_enable && outside;
  assign result.inside_res   = in_range && !(bbox_enable && outside) && parity;

endmodule

### src/pip_ctrl.sv
// ----------------------------------------------------------------------------
// pip_ctrl
// Sequencer for one edge: capture, evaluate, multiply, divide, compare,
// and result hand-off.
// ----------------------------------------------------------------------------
module pip_ctrl
  import pip_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output pip_cmd_t    cmd,
  input  pip_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIVS,
    S_DIVW,
    S_CMP,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.eval      = (state == S_EVAL);
    cmd.mul       = (state == S_MUL);
    cmd.div_start = (state == S_DIVS);
    cmd.cmp       = (state == S_CMP);
    cmd.res_load  = (state == S_FINISH) && status.last && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          if (status.match && status.straddle) state <= S_MUL;
          else state <= S_FINISH;
        end
        S_MUL:  state <= S_DIVS;
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (status.div_done) state <= S_CMP;
        end
        S_CMP:  state <= S_FINISH;
        S_FINISH: begin
          if (!status.last || out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (cmd.res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
      (in_valid && !in_stall) |=> (state == S_EVAL))
    else $error("accepted edge not evaluated");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
      cmd.res_load |-> (status.last && !(out_valid && out_stall)))
    else $error("result loaded over a pending transfer");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
      status.div_done |-> (state == S_DIVW))
    else $error("divider finished outside the wait state");
`endif

endmodule

### src/point_in_polygon_crossing_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// Streams map edges for one query point and sector, counts crossings of a
// horizontal ray, and reports inside/outside on the last edge.
// ----------------------------------------------------------------------------
// One edge is taken at a time. An edge outside the query sector, or one
// that does not straddle the point's y, goes from capture to evaluate and
// finish. A straddling edge also passes through multiply, divider start,
// divider wait and compare; the radix-2 divider works out the crossing x.
// The last edge of a query also waits while a previous result is still
// held on the output. Configuration registers are always ready.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test
  import pip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sector_t     sector_count;
  logic        bbox_enable;
  pip_cmd_t    cmd;
  pip_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count <= SECTOR_COUNT_RST;
      bbox_enable  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SECTOR_COUNT: sector_count <= cfg_data[SECTOR_W-1:0];
        REG_BBOX_ENABLE:  bbox_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  pip_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_data      (in_data),
    .sector_count (sector_count),
    .bbox_enable  (bbox_enable),
    .out_data     (out_data)
  );

endmodule
